>>> sv/tun_pkg.sv
// Shared item types for the triangle unit normal block.
package tun_pkg;

  localparam int unsigned FIELD_WIDTH = 16;

  typedef struct packed {
    logic signed [FIELD_WIDTH-1:0] ax;
    logic signed [FIELD_WIDTH-1:0] ay;
    logic signed [FIELD_WIDTH-1:0] az;
    logic signed [FIELD_WIDTH-1:0] bx;
    logic signed [FIELD_WIDTH-1:0] by;
    logic signed [FIELD_WIDTH-1:0] bz;
    logic signed [FIELD_WIDTH-1:0] cx;
    logic signed [FIELD_WIDTH-1:0] cy;
    logic signed [FIELD_WIDTH-1:0] cz;
  } face_t;

  typedef struct packed {
    logic signed [FIELD_WIDTH-1:0] nx;
    logic signed [FIELD_WIDTH-1:0] ny;
    logic signed [FIELD_WIDTH-1:0] nz;
    logic                          degenerate;
  } normal_t;

endpackage

>>> sv/tun_sqrt_cell.sv
// One bit step of the pipelined floor square root, with sideband pass-through.
module tun_sqrt_cell #(
  parameter int SW = 68,
  parameter int RW = 35,
  parameter int XW = 140
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          valid_i,
  input  logic [SW-1:0] rad_i,
  input  logic [RW+1:0] rem_i,
  input  logic [RW-1:0] root_i,
  input  logic [XW-1:0] side_i,
  output logic          valid_o,
  output logic [SW-1:0] rad_o,
  output logic [RW+1:0] rem_o,
  output logic [RW-1:0] root_o,
  output logic [XW-1:0] side_o
);

  logic [RW+3:0] cur;
  logic [RW+3:0] trial;
  logic [RW+3:0] diff;
  logic          ge;

  always_comb begin
    cur   = {rem_i, rad_i[SW-1 -: 2]};
    trial = (RW+4)'({root_i, 2'b01});
    diff  = cur - trial;
    ge    = (cur >= trial);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_o <= 1'b0;
    end else if (en) begin
      valid_o <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rad_o  <= rad_i << 2;
      rem_o  <= ge ? diff[RW+1:0] : cur[RW+1:0];
      root_o <= {root_i[RW-2:0], ge};
      side_o <= side_i;
    end
  end

endmodule

>>> sv/tun_div_cell.sv
// One quotient bit step of three parallel restoring dividers sharing a divisor.
module tun_div_cell #(
  parameter int RW = 35,
  parameter int QW = 15,
  parameter int XW = 4
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                valid_i,
  input  logic [RW-1:0]       m_i,
  input  logic [2:0][RW-1:0]  rem_i,
  input  logic [2:0][QW-1:0]  low_i,
  input  logic [2:0][QW-1:0]  q_i,
  input  logic [XW-1:0]       side_i,
  output logic                valid_o,
  output logic [RW-1:0]       m_o,
  output logic [2:0][RW-1:0]  rem_o,
  output logic [2:0][QW-1:0]  low_o,
  output logic [2:0][QW-1:0]  q_o,
  output logic [XW-1:0]       side_o
);

  logic [2:0][RW:0]   cur;
  logic [2:0][RW:0]   diff;
  logic [2:0]         ge;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      cur[i]  = {rem_i[i], low_i[i][QW-1]};
      diff[i] = cur[i] - {1'b0, m_i};
      ge[i]   = (cur[i] >= {1'b0, m_i});
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_o <= 1'b0;
    end else if (en) begin
      valid_o <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_o    <= m_i;
      side_o <= side_i;
      for (int i = 0; i < 3; i++) begin
        rem_o[i] <= ge[i] ? diff[i][RW-1:0] : cur[i][RW-1:0];
        low_o[i] <= low_i[i] << 1;
        q_o[i]   <= {q_i[i][QW-2:0], ge[i]};
      end
    end
  end

endmodule

>>> sv/triangle_unit_normal.sv
// Triangle unit normal: edges, cross product, square root and divide cell chains.
// One sqrt cell per root bit and one divide cell per quotient bit.
// Throughput: one item per cycle while the output is not stalled.
// The whole pipeline advances whenever the output register is empty or being taken.
// Reset clears all valid bits; data registers are not reset.
module triangle_unit_normal #(
  parameter int COORD_WIDTH = 16,
  parameter int FRAC_BITS   = 14
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             face_valid,
  output logic             face_stall,
  input  tun_pkg::face_t   face,
  output logic             normal_valid,
  input  logic             normal_stall,
  output tun_pkg::normal_t normal
);

  localparam int CW  = COORD_WIDTH;
  localparam int FW  = tun_pkg::FIELD_WIDTH;
  localparam int EW  = CW + 1;
  localparam int PW  = 2 * EW + 1;
  localparam int MW  = 2 * EW;
  localparam int HW  = (MW + 1) / 2;
  localparam int GW  = MW - HW;
  localparam int SW  = 2 * MW + 2;
  localparam int RW  = MW + 1;
  localparam int QW  = FRAC_BITS + 1;
  localparam int XW  = 3 * MW + 4;
  localparam int DXW = 4;
  localparam int QXW = (QW > FW + 1) ? QW : FW + 1;

  logic en;
  assign en         = !normal_valid || !normal_stall;
  assign face_stall = !en;

  // edge stage
  logic [CW-1:0]        raw [9];
  logic signed [EW-1:0] crd [9];
  logic signed [EW-1:0] e1 [3];
  logic signed [EW-1:0] e2 [3];
  logic                 v1;

  always_comb begin
    raw[0] = CW'($unsigned(face.ax));
    raw[1] = CW'($unsigned(face.ay));
    raw[2] = CW'($unsigned(face.az));
    raw[3] = CW'($unsigned(face.bx));
    raw[4] = CW'($unsigned(face.by));
    raw[5] = CW'($unsigned(face.bz));
    raw[6] = CW'($unsigned(face.cx));
    raw[7] = CW'($unsigned(face.cy));
    raw[8] = CW'($unsigned(face.cz));
    for (int i = 0; i < 9; i++) begin
      crd[i] = EW'($signed(raw[i]));
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        e1[i] <= crd[6+i] - crd[i];
        e2[i] <= crd[3+i] - crd[i];
      end
    end
  end

  // product stage
  logic signed [2*EW-1:0] pa [3];
  logic signed [2*EW-1:0] pb [3];
  logic                   v2;

  always_ff @(posedge clk) begin
    if (en) begin
      pa[0] <= e1[1] * e2[2];
      pb[0] <= e1[2] * e2[1];
      pa[1] <= e1[2] * e2[0];
      pb[1] <= e1[0] * e2[2];
      pa[2] <= e1[0] * e2[1];
      pb[2] <= e1[1] * e2[0];
    end
  end

  // cross product magnitude and sign
  logic signed [PW-1:0] d [3];
  logic [MW-1:0]        mg3 [3];
  logic [2:0]           sg3;
  logic                 dg3;
  logic                 v3;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      d[i] = PW'(pa[i]) - PW'(pb[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        sg3[i] <= d[i][PW-1];
        mg3[i] <= d[i][PW-1] ? MW'(-d[i]) : MW'(d[i]);
      end
      dg3 <= (d[0] == '0) && (d[1] == '0) && (d[2] == '0);
    end
  end

  // partial squares
  logic [2*GW-1:0] hh [3];
  logic [MW-1:0]   hl [3];
  logic [2*HW-1:0] ll [3];
  logic [MW-1:0]   mg4 [3];
  logic [2:0]      sg4;
  logic            dg4;
  logic            v4;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        hh[i]  <= mg3[i][MW-1:HW] * mg3[i][MW-1:HW];
        hl[i]  <= mg3[i][MW-1:HW] * mg3[i][HW-1:0];
        ll[i]  <= mg3[i][HW-1:0] * mg3[i][HW-1:0];
        mg4[i] <= mg3[i];
      end
      sg4 <= sg3;
      dg4 <= dg3;
    end
  end

  // squares
  logic [SW-1:0] sq [3];
  logic [MW-1:0] mg5 [3];
  logic [2:0]    sg5;
  logic          dg5;
  logic          v5;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        sq[i]  <= (SW'(hh[i]) << (2 * HW)) + (SW'(hl[i]) << (HW + 1)) + SW'(ll[i]);
        mg5[i] <= mg4[i];
      end
      sg5 <= sg4;
      dg5 <= dg4;
    end
  end

  // sum of squares
  logic [SW-1:0] ssum;
  logic [XW-1:0] side6;
  logic          v6;

  always_ff @(posedge clk) begin
    if (en) begin
      ssum  <= sq[0] + sq[1] + sq[2];
      side6 <= {dg5, sg5, mg5[2], mg5[1], mg5[0]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
      v6 <= 1'b0;
    end else if (en) begin
      v1 <= face_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
      v6 <= v5;
    end
  end

  // square root chain
  logic          sv  [RW+1];
  logic [SW-1:0] srad [RW+1];
  logic [RW+1:0] srem [RW+1];
  logic [RW-1:0] sroot [RW+1];
  logic [XW-1:0] sside [RW+1];

  assign sv[0]    = v6;
  assign srad[0]  = ssum;
  assign srem[0]  = '0;
  assign sroot[0] = '0;
  assign sside[0] = side6;

  for (genvar k = 0; k < RW; k++) begin : g_sqrt
    tun_sqrt_cell #(.SW(SW), .RW(RW), .XW(XW)) u_cell (
      .clk     (clk),
      .rst     (rst),
      .en      (en),
      .valid_i (sv[k]),
      .rad_i   (srad[k]),
      .rem_i   (srem[k]),
      .root_i  (sroot[k]),
      .side_i  (sside[k]),
      .valid_o (sv[k+1]),
      .rad_o   (srad[k+1]),
      .rem_o   (srem[k+1]),
      .root_o  (sroot[k+1]),
      .side_o  (sside[k+1])
    );
  end

  // divide chain
  logic               dv   [QW+1];
  logic [RW-1:0]      dm   [QW+1];
  logic [2:0][RW-1:0] drem [QW+1];
  logic [2:0][QW-1:0] dlow [QW+1];
  logic [2:0][QW-1:0] dq   [QW+1];
  logic [DXW-1:0]     dside [QW+1];
  logic [MW-1:0]      smag [3];

  for (genvar i = 0; i < 3; i++) begin : g_div_in
    assign smag[i]    = sside[RW][i*MW +: MW];
    assign drem[0][i] = RW'(smag[i] >> 1);
    assign dlow[0][i] = {smag[i][0], {FRAC_BITS{1'b0}}};
    assign dq[0][i]   = '0;
  end

  assign dv[0]    = sv[RW];
  assign dm[0]    = sroot[RW];
  assign dside[0] = sside[RW][XW-1 -: DXW];

  for (genvar k = 0; k < QW; k++) begin : g_div
    tun_div_cell #(.RW(RW), .QW(QW), .XW(DXW)) u_cell (
      .clk     (clk),
      .rst     (rst),
      .en      (en),
      .valid_i (dv[k]),
      .m_i     (dm[k]),
      .rem_i   (drem[k]),
      .low_i   (dlow[k]),
      .q_i     (dq[k]),
      .side_i  (dside[k]),
      .valid_o (dv[k+1]),
      .m_o     (dm[k+1]),
      .rem_o   (drem[k+1]),
      .low_o   (dlow[k+1]),
      .q_o     (dq[k+1]),
      .side_o  (dside[k+1])
    );
  end

  // sign, saturate, degenerate
  logic [QXW-1:0] qx  [3];
  logic [FW-1:0]  cmp [3];
  logic           dgf;

  always_comb begin
    dgf = dside[QW][DXW-1];
    for (int i = 0; i < 3; i++) begin
      qx[i] = QXW'(dq[QW][i]);
      if (dgf) begin
        cmp[i] = '0;
      end else if (dside[QW][i]) begin
        cmp[i] = (qx[i] > QXW'(32768)) ? FW'(16'h8000) : FW'(~qx[i] + QXW'(1));
      end else begin
        cmp[i] = (qx[i] > QXW'(32767)) ? FW'(16'h7fff) : FW'(qx[i]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      normal_valid <= 1'b0;
    end else if (en) begin
      normal_valid <= dv[QW];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      normal.nx         <= cmp[0];
      normal.ny         <= cmp[1];
      normal.nz         <= cmp[2];
      normal.degenerate <= dgf;
    end
  end

  a_degen_zero : assert property (@(posedge clk) disable iff (rst)
    normal_valid && normal.degenerate |->
      normal.nx == '0 && normal.ny == '0 && normal.nz == '0)
    else $error("degenerate item with nonzero components");

  a_stall_cause : assert property (@(posedge clk) disable iff (rst)
    face_stall |-> normal_valid && normal_stall)
    else $error("input stalled without a blocked output");

  a_reset_empty : assert property (@(posedge clk)
    rst |=> !normal_valid && !sv[RW] && !dv[QW])
    else $error("pipeline holds an item after reset");

endmodule
